### src/bmhpq_pkg.sv
// shared types and codes for the binary max-heap priority queue
// no dependencies; imported by the top level
package bmhpq_pkg;

    typedef logic signed [31:0] t_key;
    typedef logic [1:0]         t_cmd;
    typedef logic [1:0]         t_status;

    localparam t_cmd CMD_INSERT   = 2'd0;
    localparam t_cmd CMD_EXTRACT  = 2'd1;
    localparam t_cmd CMD_INCREASE = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_BAD   = 2'd3;

endpackage

### src/binary_max_heap_priority_queue.sv
// binary max-heap priority queue: one word in flight, sequencer around one key compare
// insert and increase climb the heap one level per read and compare, extract descends one
// level per read and compares, each step waiting on the registered ram read; rejected words
// end without a walk; a pending result word that is stalled holds the final step
// throughput: one word at a time, the next is taken the cycle after the result is registered
// reset (synchronous, active low) empties the heap; the key ram is not cleared; needs pkg, ram
module binary_max_heap_priority_queue #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  bmhpq_pkg::t_cmd              i_cmd,
    input  bmhpq_pkg::t_key              i_key_value,
    input  logic [$clog2(DEPTH)-1:0]     i_slot_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bmhpq_pkg::t_status           o_status,
    output bmhpq_pkg::t_key              o_extracted_key,
    output bmhpq_pkg::t_key              o_top_key,
    output logic [$clog2(DEPTH+1)-1:0]   o_entry_count
);
    import bmhpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INC_RD  = 4'd1;
    localparam logic [3:0] S_INC_CHK = 4'd2;
    localparam logic [3:0] S_SU_RD   = 4'd3;
    localparam logic [3:0] S_SU_CMP  = 4'd4;
    localparam logic [3:0] S_EX_RD   = 4'd5;
    localparam logic [3:0] S_EX_LAST = 4'd6;
    localparam logic [3:0] S_DN_RD   = 4'd7;
    localparam logic [3:0] S_DN_CMPL = 4'd8;
    localparam logic [3:0] S_DN_CMPR = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    t_key          r_val, n_val;
    t_key          r_bval, n_bval;
    logic          r_bsel, n_bsel;
    t_key          r_top;
    t_status       r_status, n_status;
    t_key          r_taken, n_taken;

    logic          r_out_valid, n_out_valid;
    t_status       r_o_status, n_o_status;
    t_key          r_o_taken, n_o_taken;
    t_key          r_o_top, n_o_top;
    logic [CW-1:0] r_o_count, n_o_count;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_key          ram_wdata;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    t_key          ram_rdata_a;
    t_key          ram_rdata_b;

    t_key          cmp_a;
    t_key          cmp_b;
    logic          cmp_lt;

    logic [XW-1:0] lc;
    logic [XW-1:0] rc;
    logic [XW-1:0] cnt_x;
    logic [AW-1:0] parent;

    bmhpq_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr_a(ram_raddr_a),
        .i_raddr_b(ram_raddr_b),
        .o_rdata_a(ram_rdata_a),
        .o_rdata_b(ram_rdata_b)
    );

    assign lc     = (XW'(r_pos) << 1) + XW'(1);
    assign rc     = (XW'(r_pos) << 1) + XW'(2);
    assign cnt_x  = XW'(r_count);
    assign parent = (r_pos - AW'(1)) >> 1;

    // the one shared key compare, operands chosen by step
    always_comb begin
        case (r_state)
            S_INC_CHK: begin
                cmp_a = r_val;
                cmp_b = ram_rdata_a;
            end
            S_SU_CMP: begin
                cmp_a = ram_rdata_a;
                cmp_b = r_val;
            end
            S_DN_CMPL: begin
                cmp_a = r_val;
                cmp_b = ram_rdata_a;
            end
            S_DN_CMPR: begin
                cmp_a = r_bval;
                cmp_b = ram_rdata_b;
            end
            default: begin
                cmp_a = r_val;
                cmp_b = ram_rdata_a;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_val       = r_val;
        n_bval      = r_bval;
        n_bsel      = r_bsel;
        n_status    = r_status;
        n_taken     = r_taken;
        n_out_valid = r_out_valid & i_out_stall;
        n_o_status  = r_o_status;
        n_o_taken   = r_o_taken;
        n_o_top     = r_o_top;
        n_o_count   = r_o_count;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_val;
        ram_raddr_a = r_pos;
        ram_raddr_b = r_pos;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_taken  = '0;
                    n_state  = S_FIN;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_val   = i_key_value;
                                n_pos   = r_count[AW-1:0];
                                n_count = r_count + CW'(1);
                                n_state = S_SU_RD;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_taken = r_top;
                                n_count = r_count - CW'(1);
                                if (r_count != CW'(1)) begin
                                    n_state = S_EX_RD;
                                end
                            end
                        end
                        CMD_INCREASE: begin
                            if (CW'(i_slot_index) >= r_count) begin
                                n_status = ST_BAD;
                            end else begin
                                n_val   = i_key_value;
                                n_pos   = i_slot_index;
                                n_state = S_INC_RD;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_INC_RD: begin
                n_state = S_INC_CHK;
            end
            S_INC_CHK: begin
                // new key below the stored one is rejected
                if (cmp_lt) begin
                    n_status = ST_BAD;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_SU_RD;
                end
            end
            S_SU_RD: begin
                ram_raddr_a = parent;
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SU_CMP;
                end
            end
            S_SU_CMP: begin
                ram_raddr_a = parent;
                ram_we      = 1'b1;
                if (cmp_lt) begin
                    // parent moves down into the hole
                    ram_wdata = ram_rdata_a;
                    n_pos     = parent;
                    n_state   = S_SU_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_EX_RD: begin
                ram_raddr_a = r_count[AW-1:0];
                n_state     = S_EX_LAST;
            end
            S_EX_LAST: begin
                n_val   = ram_rdata_a;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                ram_raddr_a = lc[AW-1:0];
                ram_raddr_b = rc[AW-1:0];
                if (lc >= cnt_x) begin
                    ram_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_DN_CMPL;
                end
            end
            S_DN_CMPL: begin
                ram_raddr_a = lc[AW-1:0];
                ram_raddr_b = rc[AW-1:0];
                if (cmp_lt) begin
                    n_bval = ram_rdata_a;
                    n_bsel = 1'b1;
                end else begin
                    n_bval = r_val;
                    n_bsel = 1'b0;
                end
                n_state = S_DN_CMPR;
            end
            S_DN_CMPR: begin
                ram_raddr_a = lc[AW-1:0];
                ram_raddr_b = rc[AW-1:0];
                ram_we      = 1'b1;
                // left wins ties, right only when strictly greater and present
                if (rc < cnt_x && cmp_lt) begin
                    ram_wdata = ram_rdata_b;
                    n_pos     = rc[AW-1:0];
                    n_state   = S_DN_RD;
                end else if (r_bsel) begin
                    ram_wdata = ram_rdata_a;
                    n_pos     = lc[AW-1:0];
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_taken   = r_taken;
                    n_o_top     = (r_count == '0) ? t_key'(0) : r_top;
                    n_o_count   = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_bval     <= n_bval;
        r_bsel     <= n_bsel;
        r_status   <= n_status;
        r_taken    <= n_taken;
        r_o_status <= n_o_status;
        r_o_taken  <= n_o_taken;
        r_o_top    <= n_o_top;
        r_o_count  <= n_o_count;
        // mirror of the root slot
        if (ram_we && ram_waddr == '0) begin
            r_top <= ram_wdata;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_extracted_key = r_o_taken;
    assign o_top_key       = r_o_top;
    assign o_entry_count   = r_o_count;

endmodule

### src/bmhpq_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
module bmhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
